// ===== src/hit_word_frame_packer_defines.svh =====
// ----------------------------------------------------------------------------
// hit_word_frame_packer_defines
// Assertion macros for the hit word frame packer. The checks compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HIT_WORD_FRAME_PACKER_DEFINES_SVH
`define HIT_WORD_FRAME_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked property check that is switched off while reset is asserted.
`define HWFP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hwfp assertion failed");
// Same check with a caller supplied message.
`define HWFP_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define HWFP_ASSERT(name, clk, rst_n, prop)
`define HWFP_ASSERT_MSG(name, clk, rst_n, prop, msg)
`endif
`endif

// ===== src/hwfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hwfp_pkg
// Field widths, fixed constants and beat types of the hit word frame packer.
// ----------------------------------------------------------------------------
package hwfp_pkg;

  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned PAD_W   = 8;
  localparam int unsigned PART_W  = 3;
  localparam int unsigned WORD_W  = PART_W + PAD_W;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ZERO_W  = 12;
  localparam int unsigned LEFT_W  = 7;
  localparam int unsigned LCNT_W  = 3;
  localparam int unsigned WCNT_W  = 3;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned ZEROS_MAX   = 4095;

  typedef enum logic {
    REQ_HIT = 1'b0,
    REQ_END = 1'b1
  } req_e;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic [ZERO_W-1:0] zeros_after;
    logic              last;
  } beat_t;

endpackage

// ===== src/hwfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// hwfp_stream_if
// Valid/ready channels of the packer: hit requests in, packed bytes out.
// ----------------------------------------------------------------------------
interface hwfp_hit_if;
  import hwfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot;
  logic [PAD_W-1:0]  pad_index;
  logic [PART_W-1:0] partition;

  modport source (output valid, req_type, slot, pad_index, partition, input ready);
  modport sink   (input valid, req_type, slot, pad_index, partition, output ready);
endinterface

interface hwfp_byte_if;
  import hwfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic [ZERO_W-1:0] zeros_after;
  logic              last;

  modport source (output valid, byte_value, zeros_after, last, input ready);
  modport sink   (input valid, byte_value, zeros_after, last, output ready);
endinterface

// ===== src/hit_word_frame_packer.sv =====
// ----------------------------------------------------------------------------
// hit_word_frame_packer
// Each item's beats pass through the beat buffer and then the output register
// before its first byte shows on the output. One item per cycle while each
// item yields at most one byte and the output is not stalled; an item with
// more bytes holds the input while they drain through the single output port. Dropped hits yield no bytes.
// Reset (asynchronous, active low) empties the beat buffer and the output
// register and puts the packer at slot 0 with an empty frame.
// ----------------------------------------------------------------------------
`include "hit_word_frame_packer_defines.svh"

module hit_word_frame_packer #(
  parameter int unsigned PAGE_BYTES      = 4096,
  parameter int unsigned WORDS_PER_FRAME = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hwfp_hit_if.sink    hits_i,
  hwfp_byte_if.source bytes_o
);
  import hwfp_pkg::*;

  // Width of the page arithmetic. It must hold both the page size and the
  // byte count of all 512 frames, plus headroom for the frame remainder.
  localparam int unsigned PAGE_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned TAIL_W = ((PAGE_W > 13) ? PAGE_W : 13) + 1;
  localparam logic [TAIL_W-1:0] PAGE_C  = TAIL_W'(PAGE_BYTES);
  localparam logic [TAIL_W-1:0] ZMAX_C  = TAIL_W'(ZEROS_MAX);
  localparam logic [WCNT_W-1:0] WPF_C   = WCNT_W'(WORDS_PER_FRAME);

  // Packing state of the open frame.
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [WCNT_W-1:0] words_q, words_d;
  logic [LEFT_W-1:0] lbits_q, lbits_d;
  logic [LCNT_W-1:0] lcnt_q, lcnt_d;

  // The beats that one item produces wait in a three entry buffer, which
  // is drained in order into the output register. Entry 0 is the head.
  beat_t      bund_q [3];
  beat_t      bund_d [3];
  logic [1:0] bund_cnt_q, bund_cnt_d;

  beat_t out_q;
  logic  out_vld_q;

  logic in_acc;
  logic in_rdy;
  logic move;

  // A beat moves from the buffer head into the output register whenever
  // that register is empty or is being emptied. New items are taken once the
  // buffer is empty or its last beat is leaving, so items that yield one byte
  // each can follow in every cycle while the output is not stalled.
  assign move   = (bund_cnt_q != 2'd0) && (!out_vld_q || bytes_o.ready);
  assign in_rdy = (bund_cnt_q == 2'd0) || ((bund_cnt_q == 2'd1) && move);
  assign in_acc = hits_i.valid && in_rdy;

  assign hits_i.ready       = in_rdy;
  assign bytes_o.valid      = out_vld_q;
  assign bytes_o.byte_value = out_q.byte_value;
  assign bytes_o.zeros_after = out_q.zeros_after;
  assign bytes_o.last       = out_q.last;

  // Classification of the incoming request.
  logic is_end, is_later, is_drop;

  // Closing byte and remainder of the open frame.
  logic [14:0]       close_sh;
  logic [BYTE_W-1:0] close_byte;
  logic [6:0]        words_x11;
  logic [ZERO_W-1:0] frame_rest;
  logic [SLOT_W-1:0] gap;
  logic [ZERO_W-1:0] z_skip;

  // Page padding for an end request.
  logic [TAIL_W-1:0] used_w, tail_w, zsum_w;
  logic [ZERO_W-1:0] z_end;

  // Word packing. A hit in a later slot packs into a fresh frame, so the
  // leftover bits are taken as empty in that case.
  logic [WORD_W-1:0] word;
  logic [LEFT_W-1:0] lb_eff;
  logic [LCNT_W-1:0] rc_eff;
  logic [14:0]       lb_sh;
  logic [3:0]        remain, remain2;
  logic [WORD_W-1:0] bits, bits2;
  logic              two;
  logic [BYTE_W-1:0] b1, b2;
  logic [WCNT_W-1:0] words_base;

  always_comb begin
    is_end   = (hits_i.req_type == REQ_END);
    is_later = !is_end && (hits_i.slot > cur_slot_q);
    is_drop  = !is_end && ((hits_i.slot < cur_slot_q) ||
               ((hits_i.slot == cur_slot_q) && (words_q >= WPF_C)));

    // The closing byte left-aligns the partial byte; with no leftover bits
    // the shift pushes everything out and the byte is zero.
    close_sh   = {8'd0, lbits_q} << (4'd8 - {1'b0, lcnt_q});
    close_byte = close_sh[BYTE_W-1:0];
    words_x11  = {4'd0, words_q} * 7'd11;
    frame_rest = ZERO_W'(FRAME_BYTES - 1) - {8'd0, words_x11[6:3]};

    gap    = hits_i.slot - cur_slot_q - 9'd1;
    z_skip = frame_rest + {gap, 3'b000};

    used_w = TAIL_W'({({1'b0, cur_slot_q} + 10'd1), 3'b000});
    tail_w = (PAGE_C > used_w) ? (PAGE_C - used_w) : '0;
    zsum_w = tail_w + TAIL_W'(frame_rest);
    z_end  = (zsum_w > ZMAX_C) ? ZERO_W'(ZEROS_MAX) : zsum_w[ZERO_W-1:0];

    word   = {hits_i.partition, hits_i.pad_index};
    lb_eff = is_later ? '0 : lbits_q;
    rc_eff = is_later ? '0 : lcnt_q;
    lb_sh  = {8'd0, lb_eff} << (4'd8 - {1'b0, rc_eff});
    remain = 4'd3 + {1'b0, rc_eff};
    b1     = lb_sh[BYTE_W-1:0] | BYTE_W'(word >> remain);
    bits   = word & ~(11'h7FF << remain);
    two    = (remain >= 4'd8);
    b2     = BYTE_W'(bits >> (remain - 4'd8));
    remain2 = two ? (remain - 4'd8) : remain;
    bits2  = bits & ~(11'h7FF << remain2);
    words_base = is_later ? '0 : words_q;
  end

  // Next state of the packer and of the beat buffer.
  always_comb begin
    beat_t c_close, c_first, c_second;

    cur_slot_d = cur_slot_q;
    words_d    = words_q;
    lbits_d    = lbits_q;
    lcnt_d     = lcnt_q;
    bund_d     = bund_q;
    bund_cnt_d = bund_cnt_q;

    c_close  = '{byte_value: close_byte, zeros_after: z_skip, last: 1'b0};
    c_first  = '{byte_value: b1, zeros_after: '0, last: !two};
    c_second = '{byte_value: b2, zeros_after: '0, last: 1'b1};

    if (move) begin
      bund_d[0]  = bund_q[1];
      bund_d[1]  = bund_q[2];
      bund_cnt_d = bund_cnt_q - 2'd1;
    end

    if (in_acc) begin
      if (is_end) begin
        bund_d[0]  = '{byte_value: close_byte, zeros_after: z_end, last: 1'b1};
        bund_cnt_d = 2'd1;
        cur_slot_d = '0;
        words_d    = '0;
        lbits_d    = '0;
        lcnt_d     = '0;
      end else if (is_drop) begin
        bund_cnt_d = 2'd0;
      end else begin
        if (is_later) begin
          bund_d[0]  = c_close;
          bund_d[1]  = c_first;
          bund_d[2]  = c_second;
          bund_cnt_d = two ? 2'd3 : 2'd2;
        end else begin
          bund_d[0]  = c_first;
          bund_d[1]  = c_second;
          bund_cnt_d = two ? 2'd2 : 2'd1;
        end
        cur_slot_d = hits_i.slot;
        words_d    = words_base + 3'd1;
        lbits_d    = bits2[LEFT_W-1:0];
        lcnt_d     = remain2[LCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q <= '0;
      words_q    <= '0;
      lbits_q    <= '0;
      lcnt_q     <= '0;
      bund_cnt_q <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      cur_slot_q <= cur_slot_d;
      words_q    <= words_d;
      lbits_q    <= lbits_d;
      lcnt_q     <= lcnt_d;
      bund_cnt_q <= bund_cnt_d;
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (bytes_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    bund_q <= bund_d;
    if (move) begin
      out_q <= bund_q[0];
    end
  end

  // A frame never holds more words than configured.
  `HWFP_ASSERT(a_words_bound, clk_i, rst_ni, words_q <= WPF_C)
  // The partial byte has no bits above its valid count.
  `HWFP_ASSERT(a_left_clean, clk_i, rst_ni, (lbits_q >> lcnt_q) == '0)
  // An end request returns the packer to an empty frame at slot 0.
  `HWFP_ASSERT_MSG(a_end_clears, clk_i, rst_ni, in_acc && is_end |=> cur_slot_q == '0 && words_q == '0 && lcnt_q == '0, "end request left state behind")
  // Without an end request the open slot only moves forward.
  `HWFP_ASSERT_MSG(a_slot_mono, clk_i, rst_ni, !(in_acc && is_end) |=> cur_slot_q >= $past(cur_slot_q), "open slot went backward")

endmodule

// ===== sim/hwfp_byte_checker.sv =====
// ----------------------------------------------------------------------------
// hwfp_byte_checker
// Watches the hit and byte channels of the packer. It predicts the packed
// byte stream from every accepted hit beat and compares each accepted byte
// beat, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module hwfp_byte_checker #(
  parameter int unsigned PAGE_BYTES      = 4096,
  parameter int unsigned WORDS_PER_FRAME = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hwfp_hit_if         hits_i,
  hwfp_byte_if        bytes_i,
  output int unsigned bytes_pending_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hwfp_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  // Mirror of the packer state.
  logic [SLOT_W-1:0] open_slot;
  logic [WCNT_W-1:0] frame_words;
  logic [LEFT_W-1:0] spill_bits;
  logic [LCNT_W-1:0] spill_count;

  beat_t       bytes_due[$];
  int unsigned miss_count;

  function automatic beat_t make_beat(input int unsigned value, input int unsigned zeros);
    beat_t b;
    b.byte_value  = value[BYTE_W-1:0];
    b.zeros_after = zeros[ZERO_W-1:0];
    b.last        = 1'b0;
    return b;
  endfunction

  // Partial byte of the open frame, padded with zeros on the right.
  function automatic int unsigned closing_byte();
    return (32'(spill_bits) << (BYTE_W - 32'(spill_count))) & 32'hFF;
  endfunction

  // Zero bytes still needed to complete the open frame.
  function automatic int unsigned frame_rest();
    return FRAME_BYTES - 1 - ((32'(frame_words) * WORD_W) >> 3);
  endfunction

  task automatic clear_frame();
    frame_words = '0;
    spill_bits  = '0;
    spill_count = '0;
  endtask

  task automatic predict_bytes(input req_e req, input logic [SLOT_W-1:0] slot,
                               input logic [PAD_W-1:0] pad, input logic [PART_W-1:0] part);
    beat_t       made[$];
    beat_t       one;
    int unsigned used;
    int unsigned tail;
    int unsigned zeros;
    int unsigned word;
    int unsigned remain;
    int unsigned bits;
    int unsigned rc;
    if (req == REQ_END) begin
      used  = FRAME_BYTES * (32'(open_slot) + 1);
      tail  = (PAGE_BYTES > used) ? PAGE_BYTES - used : 0;
      zeros = frame_rest() + tail;
      if (zeros > ZEROS_MAX) zeros = ZEROS_MAX;
      made.insert(made.size(), make_beat(closing_byte(), zeros));
      open_slot = '0;
      clear_frame();
    end else if (slot < open_slot ||
                 (slot == open_slot && frame_words >= WORDS_PER_FRAME)) begin
      // Stale slot or full frame: the hit vanishes without output.
    end else begin
      if (slot > open_slot) begin
        zeros = frame_rest() + FRAME_BYTES * (32'(slot) - 1 - 32'(open_slot));
        made.insert(made.size(), make_beat(closing_byte(), zeros));
        open_slot = slot;
        clear_frame();
      end
      word   = {part, pad};
      rc     = 32'(spill_count);
      remain = (WORD_W - BYTE_W) + rc;
      made.insert(made.size(),
                  make_beat((32'(spill_bits) << (BYTE_W - rc)) | (word >> remain), 0));
      bits = word & ((32'd1 << remain) - 1);
      if (remain >= BYTE_W) begin
        made.insert(made.size(), make_beat(bits >> (remain - BYTE_W), 0));
        remain -= BYTE_W;
        bits &= (32'd1 << remain) - 1;
      end
      spill_bits  = bits[LEFT_W-1:0];
      spill_count = remain[LCNT_W-1:0];
      frame_words = frame_words + 1'b1;
    end
    foreach (made[i]) begin
      one      = made[i];
      one.last = (i == made.size() - 1);
      bytes_due.insert(bytes_due.size(), one);
    end
  endtask

  task automatic note_miss(input string what);
    miss_count++;
    if (miss_count <= REPORT_MAX) $display("[%0t] %s", $realtime, what);
  endtask

  task automatic check_beat(input beat_t got);
    beat_t want;
    if (bytes_due.size() == 0) begin
      note_miss($sformatf("byte beat with nothing expected: byte %02h zeros %0d last %0b",
                          got.byte_value, got.zeros_after, got.last));
    end else begin
      want = bytes_due.pop_front();
      if (got.byte_value !== want.byte_value || got.zeros_after !== want.zeros_after ||
          got.last !== want.last) begin
        note_miss($sformatf({"byte beat mismatch: expected byte %02h zeros %0d last %0b,",
                             " got byte %02h zeros %0d last %0b"},
                            want.byte_value, want.zeros_after, want.last,
                            got.byte_value, got.zeros_after, got.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_slot = '0;
      clear_frame();
      bytes_due.delete();
      miss_count = 0;
      bytes_pending_o <= 0;
      mismatches_o    <= 0;
    end else begin
      if (hits_i.valid && hits_i.ready) begin
        predict_bytes(req_e'(hits_i.req_type), hits_i.slot, hits_i.pad_index,
                      hits_i.partition);
      end
      if (bytes_i.valid && bytes_i.ready) begin
        check_beat({bytes_i.byte_value, bytes_i.zeros_after, bytes_i.last});
      end
      bytes_pending_o <= bytes_due.size();
      mismatches_o    <= miss_count;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the hit word frame packer. A directed run covers
// field extremes, full frames, stale slots, slot gaps and page ends; then
// random pages of hits with random gaps on both channels. The byte checker
// beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hwfp_pkg::*;

  localparam int unsigned PAGE_BYTES      = 4096;
  localparam int unsigned WORDS_PER_FRAME = 4;
  localparam int unsigned SLOT_MAX        = (1 << SLOT_W) - 1;
  localparam int unsigned ITEMS_WANTED    = 430;
  // The receiver stalls for a long stretch once this many items have been
  // taken, and the sender drains the block once at PAUSE_AT.
  localparam int unsigned HOLD_AT         = 120;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned PAUSE_AT        = 250;
  localparam int unsigned DRAIN_CYCLES    = 20;
  // Longest legal quiet stretch is the long hold-off plus a few stalls.
  localparam int unsigned QUIET_LIMIT     = 2000;

  logic clk_i;
  logic rst_ni;

  hwfp_hit_if  hits ();
  hwfp_byte_if bytes ();

  int unsigned bytes_pending;
  int unsigned mismatches;

  // Coarse copy of the slot position, used only to steer the random hits.
  int unsigned trk_slot;
  int unsigned trk_words;
  // Items taken so far, dropped ones included.
  int unsigned items_sent;

  // Remaining items or bursts of a stretch without idling, per side.
  int unsigned send_calm;
  int unsigned sink_calm;

  hit_word_frame_packer #(
    .PAGE_BYTES      (PAGE_BYTES),
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hits_i  (hits),
    .bytes_o (bytes)
  );

  hwfp_byte_checker #(
    .PAGE_BYTES      (PAGE_BYTES),
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hits_i          (hits),
    .bytes_i         (bytes),
    .bytes_pending_o (bytes_pending),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most gaps are zero or short, a few are long, and now and then a stretch
  // of back-to-back beats starts.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void track(input req_e req, input int unsigned slot);
    if (req == REQ_END) begin
      trk_slot  = 0;
      trk_words = 0;
    end else if (slot > trk_slot || (slot == trk_slot && trk_words < WORDS_PER_FRAME)) begin
      if (slot > trk_slot) trk_words = 0;
      trk_slot = slot;
      trk_words++;
    end
  endfunction

  // Offers one hit beat after a random gap and returns at the edge that
  // takes it. Valid stays high when the next beat follows without a gap.
  task automatic send_item(input req_e req, input int unsigned slot,
                           input logic [PAD_W-1:0] pad, input logic [PART_W-1:0] part);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      hits.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hits.valid     <= 1'b1;
    hits.req_type  <= req;
    hits.slot      <= slot[SLOT_W-1:0];
    hits.pad_index <= pad;
    hits.partition <= part;
    @(posedge clk_i);
    while (!hits.ready) @(posedge clk_i);
    track(req, slot);
    items_sent++;
  endtask

  initial begin : stimulus
    int unsigned slot;
    int unsigned r;
    int unsigned page_len;
    bit          paused;

    rst_ni         = 1'b0;
    hits.valid     <= 1'b0;
    hits.req_type  <= REQ_HIT;
    hits.slot      <= '0;
    hits.pad_index <= '0;
    hits.partition <= '0;
    trk_slot       = 0;
    trk_words      = 0;
    items_sent     = 0;
    send_calm      = 0;
    paused         = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An end of page before any hit closes an empty frame at slot 0, so the
    // zero run covers the whole page.
    send_item(REQ_END, 0, 8'h00, 3'd0);
    // Four words fill slot 0, with all-ones and all-zeros words among them,
    // and a fifth hit in the same slot is dropped.
    send_item(REQ_HIT, 0, 8'hFF, 3'd7);
    send_item(REQ_HIT, 0, 8'h00, 3'd0);
    send_item(REQ_HIT, 0, 8'hAA, 3'd5);
    send_item(REQ_HIT, 0, 8'h55, 3'd2);
    send_item(REQ_HIT, 0, 8'h12, 3'd3);
    // Skip slot 1: the full frame closes and eight more zero bytes follow.
    send_item(REQ_HIT, 2, 8'h00, 3'd7);
    // A hit from an earlier slot is dropped.
    send_item(REQ_HIT, 1, 8'hC3, 3'd4);
    send_item(REQ_HIT, 2, 8'hFF, 3'd0);
    // Jump to the last slot of the page, the widest gap.
    send_item(REQ_HIT, SLOT_MAX, 8'h80, 3'd4);
    send_item(REQ_HIT, SLOT_MAX, 8'h01, 3'd1);
    // The frames fill the page, so the end request adds no page padding. Its
    // other fields are ignored and carry ones here.
    send_item(REQ_END, SLOT_MAX, 8'hFF, 3'd7);
    // A second end request in a row sees cleared state.
    send_item(REQ_END, 0, 8'h00, 3'd0);
    send_item(REQ_HIT, 256, 8'h7F, 3'd6);
    send_item(REQ_HIT, 256, 8'h80, 3'd1);
    send_item(REQ_HIT, 300, 8'h3C, 3'd2);
    send_item(REQ_END, 5, 8'h5A, 3'd3);

    // Random pages. Most hits stay in the open slot or move on by a little,
    // some jump far, and a few are stale or fully random noise. Each page
    // ends with an end request whose other fields are random.
    while (items_sent < ITEMS_WANTED) begin
      page_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(3, 30);
      if (page_len > ITEMS_WANTED - items_sent) page_len = ITEMS_WANTED - items_sent;
      repeat (page_len) begin
        r = $urandom_range(0, 99);
        if (r < 50) slot = trk_slot;
        else if (r < 78) slot = trk_slot + $urandom_range(1, 3);
        else if (r < 88) slot = trk_slot + $urandom_range(4, 300);
        else if (r < 94 && trk_slot > 0) slot = $urandom_range(0, trk_slot - 1);
        else slot = $urandom_range(0, SLOT_MAX);
        if (slot > SLOT_MAX) slot = SLOT_MAX;
        send_item(REQ_HIT, slot, PAD_W'($urandom), PART_W'($urandom));
        // Once, let the block run completely dry before going on.
        if (!paused && items_sent >= PAUSE_AT) begin
          paused = 1'b1;
          hits.valid <= 1'b0;
          do @(posedge clk_i); while (bytes_pending != 0);
        end
      end
      send_item(REQ_END, $urandom_range(0, SLOT_MAX), PAD_W'($urandom), PART_W'($urandom));
    end

    // All beats are in. Wait for the last bytes, then a little longer to
    // catch any stray beat. A missing byte ends the run at the watchdog.
    hits.valid <= 1'b0;
    do @(posedge clk_i); while (bytes_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("** hit_word_frame_packer: PASSED **");
    end else begin
      $display("** hit_word_frame_packer: FAILED **");
    end
    $finish;
  end

  // Output side: random bursts of ready with random gaps, plus one long
  // hold-off while the sender keeps offering, so the block backs up and
  // stalls its input.
  initial begin : byte_sink
    int unsigned gap;
    bit          held;
    bytes.ready <= 1'b0;
    sink_calm   = 0;
    held        = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        bytes.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      bytes.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        bytes.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((hits.valid && hits.ready) || (bytes.valid && bytes.ready)) quiet = 0;
      else quiet++;
    end
    $display("** hit_word_frame_packer: FAILED **");
    $finish;
  end

endmodule

// ===== hit_word_frame_packer.f =====
+incdir+src
src/hwfp_pkg.sv
src/hwfp_stream_if.sv
src/hit_word_frame_packer.sv
sim/hwfp_byte_checker.sv
sim/tb_top.sv
